FILE: sv/crm_pkg.sv
// Package for the convolutional code rate matcher: sizes, the column
// permutation table and the structs shared by the sequencer and the walker.
// No dependencies.
`default_nettype none

package crm_pkg;

   localparam int MAX_STREAM_BITS = 128;
   localparam int MAX_OUT_BITS    = 8192;
   localparam int NUM_STREAMS     = 3;
   localparam int NUM_COLS        = 32;
   localparam int STORE_DEPTH     = NUM_STREAMS * MAX_STREAM_BITS;

   localparam int COL_W    = $clog2(NUM_COLS);
   localparam int ROWS_MAX = (MAX_STREAM_BITS + NUM_COLS - 1) / NUM_COLS;
   localparam int ROW_W    = (ROWS_MAX > 1) ? $clog2(ROWS_MAX) : 1;
   localparam int ROWS_W   = $clog2(ROWS_MAX + 1);
   localparam int D_W      = $clog2(MAX_STREAM_BITS + 1);
   localparam int IDX_W    = ROW_W + COL_W;
   localparam int KP_W     = $clog2(ROWS_MAX * NUM_COLS + 1);
   localparam int ADDR_W   = $clog2(STORE_DEPTH);
   localparam int CNT_W    = $clog2(STORE_DEPTH + 1);
   localparam int STR_W    = 2;
   localparam int OUT_W    = 14;

   localparam logic [0:0] ACT_LOAD = 1'b0;
   localparam logic [0:0] ACT_EMIT = 1'b1;

   localparam logic [COL_W-1:0] COL_PERM [NUM_COLS] = '{
      5'd1, 5'd17, 5'd9,  5'd25, 5'd5, 5'd21, 5'd13, 5'd29,
      5'd3, 5'd19, 5'd11, 5'd27, 5'd7, 5'd23, 5'd15, 5'd31,
      5'd0, 5'd16, 5'd8,  5'd24, 5'd4, 5'd20, 5'd12, 5'd28,
      5'd2, 5'd18, 5'd10, 5'd26, 5'd6, 5'd22, 5'd14, 5'd30
   };

   typedef struct packed {
      logic clear;
      logic step;
   } crm_walk_ctrl_type;

   typedef struct packed {
      logic              hit;
      logic [ADDR_W-1:0] addr;
   } crm_walk_stat_type;

endpackage

`default_nettype wire

FILE: sv/crm_bit_store.sv
// Bit store for the three loaded streams: one write port, one registered
// read port. Depends on crm_pkg.
`default_nettype none

module crm_bit_store
   import crm_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              we,
   input  wire logic [ADDR_W-1:0] waddr,
   input  wire logic              wdata,
   input  wire logic              re,
   input  wire logic [ADDR_W-1:0] raddr,
   output logic                   rdata
);

   logic mem [STORE_DEPTH];
   logic rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   // Read data holds until the next read so a stalled result can wait on it.
   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

FILE: sv/crm_walker.sv
// Circular-buffer walker: holds the read position as stream, column and row,
// tests each position for a dummy, stepping one position a cycle while step is set, and forms its store address.
// Depends on crm_pkg.
`default_nettype none

module crm_walker
   import crm_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire crm_walk_ctrl_type ctrl,
   input  wire logic [D_W-1:0]    d,
   output crm_walk_stat_type      stat
);

   logic [STR_W-1:0]  str_ff, str_in;
   logic [COL_W-1:0]  col_ff, col_in;
   logic [ROW_W-1:0]  row_ff, row_in;

   logic [D_W:0]      rows_sum;
   logic [ROWS_W-1:0] rows;
   logic [KP_W-1:0]   kp;
   logic [KP_W-1:0]   nd;
   logic [KP_W-1:0]   idx;
   logic [IDX_W-1:0]  off;
   logic              row_last;

   assign rows_sum = {1'b0, d} + (D_W+1)'(NUM_COLS - 1);
   assign rows     = ROWS_W'(rows_sum >> COL_W);
   assign kp       = KP_W'({rows, {COL_W{1'b0}}});
   assign nd       = kp - KP_W'(d);

   // Row-major index inside the matrix; positions below nd are dummies.
   assign idx = KP_W'({row_ff, COL_PERM[col_ff]});
   assign off = IDX_W'(idx - nd);

   assign stat.hit  = (idx >= nd);
   assign stat.addr = ADDR_W'({off, 1'b0}) + ADDR_W'(off) + ADDR_W'(str_ff);

   assign row_last = (ROWS_W'(row_ff) == rows - ROWS_W'(1));

   always_comb begin
      str_in = str_ff;
      col_in = col_ff;
      row_in = row_ff;
      if (ctrl.clear) begin
         str_in = '0;
         col_in = '0;
         row_in = '0;
      end else if (ctrl.step) begin
         if (!row_last) begin
            row_in = row_ff + ROW_W'(1);
         end else begin
            row_in = '0;
            if (col_ff != COL_W'(NUM_COLS - 1)) begin
               col_in = col_ff + COL_W'(1);
            end else begin
               col_in = '0;
               str_in = (str_ff == STR_W'(NUM_STREAMS - 1)) ? '0 : str_ff + STR_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         str_ff <= '0;
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         str_ff <= str_in;
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

endmodule

`default_nettype wire

FILE: sv/conv_code_rate_matcher.sv
// Rate matcher for a rate-1/3 convolutional code: a load beat is taken in ST_IDLE, which it
// does not leave. An emit beat is accepted in ST_IDLE; then in ST_SCAN the walker tests at
// least one buffer position, one a cycle (dummies skipped), until a hit; then ST_READ takes
// the registered store read and repeats while the previous result beat is still held. An emit
// that gives nothing stays in ST_IDLE. Synchronous active-high reset clears control state and sets
// out_len to 1; the bit store is not cleared and needs no clearing pass.
`default_nettype none

module conv_code_rate_matcher
   import crm_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   // Input beats.
   input  wire logic             req_tvalid,
   output logic                  req_tready,
   input  wire logic [7:0]       req_tdata,   // [0] coded_bit, [7:1] zero
   input  wire logic             req_tuser,   // [0] action
   input  wire logic             req_tlast,   // load_last
   // Result beats.
   output logic                  rsp_tvalid,
   input  wire logic             rsp_tready,
   output logic [7:0]            rsp_tdata,   // [0] out_bit, [7:1] zero
   output logic                  rsp_tlast,   // out_last
   // Configuration.
   input  wire logic             csr_we,
   input  wire logic [OUT_W-1:0] csr_wdata    // out_len
);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_SCAN = 3'b010,
      ST_READ = 3'b100
   } state_type;

   state_type         state_ff, state_in;
   logic [OUT_W-1:0]  out_len_ff, out_len_in;
   logic [CNT_W-1:0]  loaded_ff, loaded_in;
   logic [1:0]        phase_ff, phase_in;
   logic [D_W-1:0]    d_ff, d_in;
   logic              ready_ff, ready_in;
   logic [OUT_W-1:0]  emitted_ff, emitted_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_bit_ff, rsp_bit_in;
   logic              rsp_last_ff, rsp_last_in;

   logic              req_acc, load_acc, emit_acc, emit_ok;
   logic              out_free;
   logic [OUT_W-1:0]  limit;
   logic [OUT_W-1:0]  emitted_next;
   logic [CNT_W-1:0]  base_cnt;
   logic [1:0]        base_ph;
   logic [D_W-1:0]    base_d;
   logic              room;

   logic              ram_we, ram_re, ram_q;
   crm_walk_ctrl_type walk_ctrl;
   crm_walk_stat_type walk_stat;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_acc    = req_tvalid && req_tready;
   assign load_acc   = req_acc && (req_tuser == ACT_LOAD);
   assign emit_acc   = req_acc && (req_tuser == ACT_EMIT);

   assign limit = (out_len_ff > OUT_W'(MAX_OUT_BITS)) ? OUT_W'(MAX_OUT_BITS) : out_len_ff;
   assign emit_ok = ready_ff && (d_ff != '0) && (emitted_ff < limit);
   assign emitted_next = emitted_ff + OUT_W'(1);
   assign out_free = !rsp_valid_ff || rsp_tready;

   // A load after a finished block starts a new one from address zero.
   assign base_cnt = ready_ff ? '0 : loaded_ff;
   assign base_ph  = ready_ff ? '0 : phase_ff;
   assign base_d   = ready_ff ? '0 : d_ff;
   assign room     = (base_cnt < CNT_W'(STORE_DEPTH));
   assign ram_we   = load_acc && room;

   assign walk_ctrl.clear = load_acc;
   assign walk_ctrl.step  = (state_ff == ST_SCAN);
   assign ram_re          = (state_ff == ST_SCAN) && walk_stat.hit;

   always_comb begin
      state_in     = state_ff;
      out_len_in   = csr_we ? csr_wdata : out_len_ff;
      loaded_in    = loaded_ff;
      phase_in     = phase_ff;
      d_in         = d_ff;
      ready_in     = ready_ff;
      emitted_in   = emitted_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_bit_in   = rsp_bit_ff;
      rsp_last_in  = rsp_last_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (load_acc) begin
               loaded_in  = room ? base_cnt + CNT_W'(1) : base_cnt;
               phase_in   = base_ph;
               d_in       = base_d;
               if (room) begin
                  // Every third stored bit completes one triple.
                  phase_in = (base_ph == 2'd2) ? 2'd0 : base_ph + 2'd1;
                  if (base_ph == 2'd2) begin
                     d_in = base_d + D_W'(1);
                  end
               end
               ready_in   = req_tlast;
               emitted_in = '0;
            end else if (emit_acc && emit_ok) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (walk_stat.hit) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_bit_in   = ram_q;
               rsp_last_in  = (emitted_next == limit);
               emitted_in   = emitted_next;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_len_ff   <= OUT_W'(1);
         loaded_ff    <= '0;
         phase_ff     <= '0;
         d_ff         <= '0;
         ready_ff     <= 1'b0;
         emitted_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_len_ff   <= out_len_in;
         loaded_ff    <= loaded_in;
         phase_ff     <= phase_in;
         d_ff         <= d_in;
         ready_ff     <= ready_in;
         emitted_ff   <= emitted_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_bit_ff  <= rsp_bit_in;
      rsp_last_ff <= rsp_last_in;
   end

   crm_bit_store u_store (
      .clock (clock),
      .we    (ram_we),
      .waddr (ADDR_W'(base_cnt)),
      .wdata (req_tdata[0]),
      .re    (ram_re),
      .raddr (walk_stat.addr),
      .rdata (ram_q)
   );

   crm_walker u_walker (
      .clock (clock),
      .reset (reset),
      .ctrl  (walk_ctrl),
      .d     (d_ff),
      .stat  (walk_stat)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'b0, rsp_bit_ff};
   assign rsp_tlast  = rsp_last_ff;

endmodule

`default_nettype wire

FILE: sv/crm_checker.sv
// Port-level checker for conv_code_rate_matcher, attached by bind below.
// Depends on crm_pkg.
`default_nettype none

module crm_checker
   import crm_pkg::*;
(
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_tvalid,
   input wire logic       req_tready,
   input wire logic       req_tuser,
   input wire logic       rsp_tvalid,
   input wire logic       rsp_tready,
   input wire logic [7:0] rsp_tdata,
   input wire logic       rsp_tlast
);

   logic load_beat;

   assign load_beat = req_tvalid && req_tready && (req_tuser == ACT_LOAD);

   // A waiting result beat holds its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("result beat changed while stalled");

   // A load does not leave idle, so the input side is still ready after it.
   a_load_one_cycle: assert property (@(posedge clock) disable iff (reset)
      load_beat |=> req_tready)
      else $error("load beat did not return to ready");

   // A load never produces a result beat.
   a_load_no_result: assert property (@(posedge clock) disable iff (reset)
      load_beat |=> !$rose(rsp_tvalid))
      else $error("result beat appeared after a load");

   // A new result only comes out of a busy emit, never straight from idle.
   a_result_from_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> !$past(req_tready))
      else $error("result beat without an emit in progress");

endmodule

bind conv_code_rate_matcher crm_checker u_crm_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);

`default_nettype wire
